### rtl/core/mlbp_pkg.sv
// ----------------------------------------------------------------------------
// mlbp_pkg
// Shared types and constants for the 2x2 mean LBP block.
// ----------------------------------------------------------------------------
`default_nettype none

package mlbp_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int CODE_W    = 4;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int MIN_DIM   = 2;
  localparam int Q_DEPTH   = 4;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One classified pixel: interior code and/or border pass-through
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               has_int;
    logic               has_bdr;
  } work_t;

endpackage

`default_nettype wire

### rtl/core/mlbp_front.sv
// ----------------------------------------------------------------------------
// mlbp_front
// Position tracking, line store and 2x2 code evaluation; emits work entries.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbp_front #(
  parameter int MAX_WIDTH  = mlbp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mlbp_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mlbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mlbp_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mlbp_pkg::PIX_W-1:0]     in_pixel_value,
  output logic                                wq_valid,
  input  wire logic                           wq_ready,
  output mlbp_pkg::work_t                     wq_data
);
  import mlbp_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HD_W  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int SUM_W = PIX_W + 2;

  logic [CFG_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             clr_active_r;
  logic [COL_W-1:0] clr_addr_r;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_q;

  logic               s1_valid_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic [COORD_W-1:0] s1_row_r, s1_col_r;
  logic               s1_int_r, s1_bdr_r;
  logic [PIX_W-1:0]   ul_r, ll_r;

  logic [WD_W-1:0] w_raw, w_eff, c_w, c_n;
  logic [HD_W-1:0] h_raw, h_eff, r_t, r_w, r_n;
  logic            wrap_in, is_int, is_bdr, accept, s1_go, s1_any;
  logic [SUM_W-1:0] sum;
  logic [CODE_W-1:0] code;
  logic             mem_we;
  logic [COL_W-1:0] mem_wa;
  logic [PIX_W-1:0] mem_wd;

  // Dimension clamp to 2..MAX
  always_comb begin
    w_raw = WD_W'(width_r);
    h_raw = HD_W'(height_r);
    if (w_raw < WD_W'(MIN_DIM))        w_eff = WD_W'(MIN_DIM);
    else if (w_raw > WD_W'(MAX_WIDTH)) w_eff = WD_W'(MAX_WIDTH);
    else                               w_eff = w_raw;
    if (h_raw < HD_W'(MIN_DIM))         h_eff = HD_W'(MIN_DIM);
    else if (h_raw > HD_W'(MAX_HEIGHT)) h_eff = HD_W'(MAX_HEIGHT);
    else                                h_eff = h_raw;
  end

  // Position of the arriving pixel, and of the next one
  always_comb begin
    wrap_in = (WD_W'(col_r) >= w_eff);
    c_w     = wrap_in ? '0 : WD_W'(col_r);
    r_t     = wrap_in ? (HD_W'(row_r) + HD_W'(1)) : HD_W'(row_r);
    r_w     = (r_t >= h_eff) ? '0 : r_t;
    c_n     = c_w + WD_W'(1);
    r_n     = r_w + HD_W'(1);
    if (c_n >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_n >= h_eff) ? '0 : ROW_W'(r_n);
    end else begin
      col_nxt = COL_W'(c_n);
      row_nxt = ROW_W'(r_w);
    end
    is_int = (r_w >= HD_W'(2)) && (c_w >= WD_W'(2));
    is_bdr = (r_w == '0) || (r_w == h_eff - HD_W'(1)) ||
             (c_w == '0) || (c_w == w_eff - WD_W'(1));
  end

  // Window evaluation: tl = ul_r, tr = rd_q, bl = ll_r, br = s1_pix_r
  always_comb begin
    sum = SUM_W'(ul_r) + SUM_W'(rd_q) + SUM_W'(ll_r) + SUM_W'(s1_pix_r);
    code[0] = ({ll_r, 2'b00}     >= sum);
    code[1] = ({ul_r, 2'b00}     >= sum);
    code[2] = ({rd_q, 2'b00}     >= sum);
    code[3] = ({s1_pix_r, 2'b00} >= sum);
  end

  assign s1_any   = s1_int_r | s1_bdr_r;
  assign s1_go    = s1_valid_r & (wq_ready | ~s1_any);
  assign in_ready = ~clr_active_r & (~s1_valid_r | s1_go);
  assign accept   = in_valid & in_ready;

  assign wq_valid        = s1_valid_r & s1_any;
  assign wq_data.code    = code;
  assign wq_data.pix     = s1_pix_r;
  assign wq_data.row     = s1_row_r;
  assign wq_data.col     = s1_col_r;
  assign wq_data.has_int = s1_int_r;
  assign wq_data.has_bdr = s1_bdr_r;

  assign mem_we = clr_active_r | accept;
  assign mem_wa = clr_active_r ? clr_addr_r : c_w[COL_W-1:0];
  assign mem_wd = clr_active_r ? '0 : in_pixel_value;

  // Line store: read-before-write on the same address
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_q <= line_mem[c_w[COL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_pixel_value;
      s1_row_r <= COORD_W'(r_w);
      s1_col_r <= COORD_W'(c_w);
      s1_int_r <= is_int;
      s1_bdr_r <= is_bdr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= RST_FRAME_WIDTH;
      height_r     <= RST_FRAME_HEIGHT;
      col_r        <= '0;
      row_r        <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      ul_r         <= '0;
      ll_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  width_r  <= cfg_data;
          REG_FRAME_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (clr_active_r) begin
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) clr_active_r <= 1'b0;
        clr_addr_r <= clr_addr_r + COL_W'(1);
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (s1_go) begin
        ul_r <= rd_q;
        ll_r <= s1_pix_r;
      end
      if (accept)     s1_valid_r <= 1'b1;
      else if (s1_go) s1_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mlbp_fifo.sv
// ----------------------------------------------------------------------------
// mlbp_fifo
// Short work queue between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbp_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire mlbp_pkg::work_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output mlbp_pkg::work_t      pop_data
);
  import mlbp_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  work_t            q_mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = q_mem[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) q_mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop)      count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/mlbp_back.sv
// ----------------------------------------------------------------------------
// mlbp_back
// Expands each work entry into one or two results on the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbp_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         head_valid,
  output logic                              head_pop,
  input  wire mlbp_pkg::work_t              head_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [mlbp_pkg::PIX_W-1:0]        out_pixel,
  output logic [mlbp_pkg::COORD_W-1:0]      out_row,
  output logic [mlbp_pkg::COORD_W-1:0]      out_col,
  output logic                              out_last_of_run
);
  import mlbp_pkg::*;

  logic               out_valid_r, last_r, phase_r;
  logic [PIX_W-1:0]   pix_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic               load, emit, emit_int, split;

  assign load     = ~out_valid_r | out_ready;
  assign emit     = load & head_valid;
  // interior result goes first when both are due
  assign emit_int = head_data.has_int & ~phase_r;
  assign split    = emit_int & head_data.has_bdr;
  assign head_pop = emit & ~split;

  assign out_valid       = out_valid_r;
  assign out_pixel       = pix_r;
  assign out_row         = row_r;
  assign out_col         = col_r;
  assign out_last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      if (emit_int) begin
        pix_r  <= PIX_W'(head_data.code);
        row_r  <= head_data.row - COORD_W'(1);
        col_r  <= head_data.col - COORD_W'(1);
        last_r <= ~head_data.has_bdr;
      end else begin
        pix_r  <= head_data.pix;
        row_r  <= head_data.row;
        col_r  <= head_data.col;
        last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (load) out_valid_r <= head_valid;
      if (emit) phase_r <= split;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mean_lbp_2x2.sv
// ----------------------------------------------------------------------------
// mean_lbp_2x2
// Streaming 2x2 mean local binary pattern over a raster-order grey image.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one 8-bit grey pixel per transaction, raster order, row-major.
//   out_* : results; an interior pixel gives a 4-bit code (bit0 bottom-left,
//           bit1 top-left, bit2 top-right, bit3 bottom-right, set where
//           4*pixel >= window sum), a border pixel passes through unchanged.
//           out_last_of_run flags the final result caused by one pixel.
//   cfg_* : frame_width (index 0) and frame_height (index 1), written only
//           while idle; values outside 2..MAX are clamped in use.
// Path: an input passes the front stage register, the work queue and the
//   output register on its way to out_*. Throughput: one pixel per cycle
//   while each pixel yields at most one result and the receiver does not
//   stall; pixels yielding two results (last row, last column) are slowed by the single-result output register.
// Reset: the line store is swept to zero, one entry per cycle, over all
//   MAX_WIDTH entries (1024 by default); in_ready stays low meanwhile.
//   Configuration writes are taken during the sweep.
// Stall: a stalled receiver holds the output register; the four-entry
//   work queue then fills and in_ready drops until space frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_lbp_2x2 #(
  parameter int MAX_WIDTH  = mlbp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mlbp_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mlbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mlbp_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mlbp_pkg::PIX_W-1:0]     in_pixel_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mlbp_pkg::PIX_W-1:0]          out_pixel,
  output logic [mlbp_pkg::COORD_W-1:0]        out_row,
  output logic [mlbp_pkg::COORD_W-1:0]        out_col,
  output logic                                out_last_of_run
);
  import mlbp_pkg::*;

  // front -> queue
  logic  wq_valid, wq_ready;
  work_t wq_data;
  // queue -> back
  logic  hd_valid, hd_pop;
  work_t hd_data;

  // Front: counters, line store, code evaluation
  mlbp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_value(in_pixel_value),
    .wq_valid      (wq_valid),
    .wq_ready      (wq_ready),
    .wq_data       (wq_data)
  );

  // Decoupling queue: lets the back end emit two results for one pixel
  mlbp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(wq_valid),
    .push_ready(wq_ready),
    .push_data (wq_data),
    .pop_valid (hd_valid),
    .pop_ready (hd_pop),
    .pop_data  (hd_data)
  );

  // Back: one result per cycle onto the output register while the receiver takes them
  mlbp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (hd_valid),
    .head_pop       (hd_pop),
    .head_data      (hd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_last_of_run(out_last_of_run)
  );

endmodule

`default_nettype wire

### rtl/core/mlbp_checker.sv
// ----------------------------------------------------------------------------
// mlbp_checker
// Port-level checks for mean_lbp_2x2, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbp_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [mlbp_pkg::PIX_W-1:0]     out_pixel,
  input wire logic [mlbp_pkg::COORD_W-1:0]   out_row,
  input wire logic [mlbp_pkg::COORD_W-1:0]   out_col,
  input wire logic                           out_last_of_run
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) &&
      $stable(out_row) && $stable(out_col) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // pending input stays
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped before transaction");

  // no input taken right after reset (line store sweep)
  a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("input taken during line store sweep");

  // a non-final result is always an interior code
  a_mid_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_pixel <= 8'd15)
    else $error("non-final result is not an LBP code");

  // interior code is followed at once by the border result one row and one column on
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=>
      out_valid && out_last_of_run && (out_col == $past(out_col) + 10'd1) &&
      (out_row == $past(out_row) + 10'd1))
    else $error("border result did not follow its interior code");

endmodule

bind mean_lbp_2x2 mlbp_checker u_mlbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pixel      (out_pixel),
  .out_row        (out_row),
  .out_col        (out_col),
  .out_last_of_run(out_last_of_run)
);

`default_nettype wire

### tb/mean_lbp_2x2_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_lbp_2x2_tb
// Self-checking bench for the streaming 2x2 mean LBP block.
// Pixels go in over valid/ready. A behavioural model of the line store and
// position counters predicts every result. Each result transaction is
// checked field by field against the oldest prediction. Directed frames
// cover the corner cases, then random frames run under several idle and
// stall patterns.
// ----------------------------------------------------------------------------
module mean_lbp_2x2_tb;
  import mlbp_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 8;     // lets pixels still in the pipeline finish
  localparam int WATCHDOG_LIMIT = 5000;  // covers the line-store sweep after reset

  // One expected or observed result transaction
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last_flag;
  } lbp_result_t;

  // DUT connections; every input starts at a known value
  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data        = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_value  = '0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [PIX_W-1:0]     out_pixel;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic                 out_last_of_run;

  // Behavioural copy of the block state
  logic [PIX_W-1:0] line_mem [DEF_MAX_WIDTH];
  logic [PIX_W-1:0] upper_left;
  logic [PIX_W-1:0] lower_left;
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  lbp_result_t      pending_results [$];
  int unsigned      err_count;
  int unsigned      quiet_cycles;
  int unsigned      sender_idle_pct;
  int unsigned      recv_stall_pct;
  logic [PIX_W-1:0] pix_base;

  mean_lbp_2x2 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel       (out_pixel),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Dimension in use: the register keeps its bits, the block clamps
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the model by one accepted pixel and queue what it yields:
  // the interior code for (r-1,c-1) first, then the border pass-through.
  task automatic predict_lbp(input logic [PIX_W-1:0] pix);
    int unsigned w, h, r, c, tl, tr, bl, br, sum;
    logic [3:0]  code;
    lbp_result_t res [$];

    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    // counters may be stale after a resize mid-frame
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;

    tl = upper_left;
    tr = line_mem[c];
    bl = lower_left;
    br = pix;

    if (r >= 2 && c >= 2) begin
      sum  = tl + tr + bl + br;
      // 4*p >= sum is the exact form of p >= mean
      code = {(4 * br >= sum), (4 * tr >= sum), (4 * tl >= sum), (4 * bl >= sum)};
      res.push_back('{pixel: PIX_W'(code), row: COORD_W'(r - 1),
                      col: COORD_W'(c - 1), last_flag: 1'b0});
    end
    if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
      res.push_back('{pixel: pix, row: COORD_W'(r), col: COORD_W'(c),
                      last_flag: 1'b0});
    if (res.size() > 0) res[res.size() - 1].last_flag = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);

    upper_left  = line_mem[c];
    line_mem[c] = pix;
    lower_left  = pix;

    col_pos = c + 1;
    row_pos = r;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("[%0t] error: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_result();
    lbp_result_t exp_r;
    if (pending_results.size() == 0) begin
      report_error($sformatf("unexpected result pix %0d at (%0d,%0d)",
                             out_pixel, out_row, out_col));
      return;
    end
    exp_r = pending_results.pop_front();
    if (out_pixel !== exp_r.pixel)
      report_error($sformatf("out_pixel at (%0d,%0d): got %0d expected %0d",
                             exp_r.row, exp_r.col, out_pixel, exp_r.pixel));
    if (out_row !== exp_r.row)
      report_error($sformatf("out_row: got %0d expected %0d", out_row, exp_r.row));
    if (out_col !== exp_r.col)
      report_error($sformatf("out_col: got %0d expected %0d", out_col, exp_r.col));
    if (out_last_of_run !== exp_r.last_flag)
      report_error($sformatf("out_last_of_run at (%0d,%0d): got %0b expected %0b",
                             exp_r.row, exp_r.col, out_last_of_run, exp_r.last_flag));
  endtask

  // Receiver: take a transaction when one is offered, then pick the next
  // ready level. A zero stall rate keeps ready high throughout.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: counts cycles without a transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; all are entered and left on a rising edge
  // --------------------------------------------------------------------------

  // Offer one pixel, with a random gap first, and hold it until taken.
  // valid is only lowered inside a gap, so it never drops and rises in
  // the same step.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    do @(posedge clk); while (!in_ready);
    predict_lbp(pix);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Pixels with no result may still be in flight: allow for the latency
  task automatic drain_results();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // Mostly small frames; now and then below the minimum or past the maximum
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return CFG_W'(0);
      1:       return CFG_W'(1);
      2:       return CFG_W'($urandom_range(DEF_MAX_WIDTH + 1, 2047));
      default: return CFG_W'($urandom_range(2, 9));
    endcase
  endfunction

  // Near-equal pixels make ties in the mean compare likely
  function automatic logic [PIX_W-1:0] next_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return {pix_base[PIX_W-1:2], 2'($urandom)};
      4:       return pix_base;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A few pixels under the reset geometry: top row, all pass-through
  task automatic test_reset_geometry();
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'h55);
    send_pixel(8'haa);
    drain_results();
  endtask

  // Shrink the width mid-row so the position jumps to the next row, then
  // finish that frame, wrap to a new one, and end on a flat field where
  // every compare ties.
  task automatic test_mid_frame_resize();
    logic [PIX_W-1:0] pattern [20] = '{
      8'h00, 8'hff, 8'h00, 8'hff,
      8'hff, 8'h00, 8'hff, 8'h00,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80
    };
    set_frame(CFG_W'(4), CFG_W'(3));
    foreach (pattern[i]) send_pixel(pattern[i]);
    drain_results();
  endtask

  // Register values outside the legal range are clamped in use
  task automatic test_clamped_dims();
    set_frame(CFG_W'(1), CFG_W'(2047));
    repeat (4) send_pixel(PIX_W'($urandom));
    drain_results();
    set_frame(CFG_W'(0), CFG_W'(0));
    repeat (4) send_pixel(PIX_W'($urandom));
    drain_results();
  endtask

  // Largest frame size written as itself: a short run along the top row
  task automatic test_max_dims();
    set_frame(CFG_W'(DEF_MAX_WIDTH), CFG_W'(DEF_MAX_HEIGHT));
    repeat (16) send_pixel(PIX_W'($urandom));
    drain_results();
  endtask

  // One random frame geometry; optionally hold off halfway until the
  // output side has caught up completely
  task automatic run_segment(input int unsigned n_items, input bit hold_off);
    set_frame(pick_dim(), pick_dim());
    pix_base = PIX_W'($urandom);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (hold_off && i == n_items / 2) wait_idle();
      send_pixel(next_pixel());
    end
    drain_results();
  endtask

  task automatic test_random_frames();
    int unsigned idle_pct  [4] = '{0, 46, 0, 25};
    int unsigned stall_pct [4] = '{0, 0, 46, 25};
    foreach (idle_pct[p]) begin
      sender_idle_pct = idle_pct[p];
      recv_stall_pct  = stall_pct[p];
      run_segment(57, 1'b1);
      run_segment(57, 1'b0);
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    err_count       = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    pix_base        = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    upper_left = '0;
    lower_left = '0;
    row_pos    = 0;
    col_pos    = 0;
    width_reg  = RST_FRAME_WIDTH;
    height_reg = RST_FRAME_HEIGHT;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // in_ready stays low through the line-store sweep; send_pixel waits
    test_reset_geometry();
    test_mid_frame_resize();
    test_clamped_dims();
    test_max_dims();
    test_random_frames();

    drain_results();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
